[hdl/xtea2_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtea2_pkg
// Shared types, constants and round functions of the XTEA-2 block cipher.
// ----------------------------------------------------------------------------
package xtea2_pkg;

    localparam logic [31:0] XT_DELTA    = 32'h9E3779B9;
    localparam logic [4:0]  XT_ROT_MASK = 5'h1F;

    localparam int          CFG_ADDR_W      = 3;
    localparam int          CFG_DATA_W      = 32;
    localparam int          ROUND_W         = 8;

    // register indexes on the config port
    localparam logic [CFG_ADDR_W-1:0] CFG_ROUND_COUNT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_WORD0   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_WORD1   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_WORD2   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_WORD3   = 3'd4;

    localparam logic [ROUND_W-1:0]    ROUND_RESET     = 8'd64;

    localparam logic CMD_ENCIPHER = 1'b0;
    localparam logic CMD_DECIPHER = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;     // take the input beat, apply whitening
        logic step;     // one half round
        logic phase;    // 0: first half, 1: second half of a round
        logic finish;   // final whitening into the output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last_round;  // round counter at its final round
        logic no_rounds;   // configured round count is zero
    } t_dp_status;

    function automatic logic [31:0] mix(input logic [31:0] x);
        return (x << 4) ^ (x >> 5);
    endfunction

    function automatic logic [31:0] rot_left(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] t;
        t = {x, x} << (n & XT_ROT_MASK);
        return t[63:32];
    endfunction

    // round function of one Feistel update
    function automatic logic [31:0] feistel(input logic [31:0] p, input logic [31:0] q,
                                            input logic [31:0] s, input logic [31:0] k);
        return mix(p) + (q ^ s) + rot_left(k, p[4:0]);
    endfunction

endpackage

[hdl/xtea2_block_cipher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtea2_block_cipher
// XTEA-2 encipher / decipher of one 128-bit block with a 128-bit key.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                      payload
//  -------   ---  -----------------------------  ---------------------------
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: 4 block words,
//                                                tuser: cmd
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: 4 result words
//  cfg       in   i_cfg_we (no ready)            index + 32-bit data
//
//  Sequencing: one block at a time, R the configured round count. A
//  single shared Feistel unit does one half round per cycle; load and
//  final whitening are separate steps before and after the 2*R half rounds.
//  Reset: synchronous, active low; round count returns to 64, key to zero.
//  Stalls: the result sits in an output register, so the next block is
//  accepted while it waits; only the final whitening waits for that
//  register to drain.
//
module xtea2_block_cipher (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write port
    input  logic                                i_cfg_we,
    input  logic [xtea2_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [xtea2_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // input block stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [127:0]                        s_axis_tdata,  // in_word0..in_word3
    input  logic [0:0]                          s_axis_tuser,  // cmd
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [127:0]                        m_axis_tdata   // out_word0..out_word3
);

    xtea2_pkg::t_dp_cmd    w_cmd;
    xtea2_pkg::t_dp_status w_status;

    // sequencing: idle -> half rounds -> final whitening
    xtea2_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // key schedule, block words and the shared round unit
    xtea2_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_dir    (s_axis_tuser[0]),
        .i_in_block  (s_axis_tdata),
        .o_out_block (m_axis_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

`ifndef SYNTHESIS
    // a block is in flight right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted again while a block is in flight");

    // final whitening never overwrites a result that is still held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.finish && m_axis_tvalid && !m_axis_tready))
        else $error("output register overwritten before it was taken");

    // load, round step and finish are mutually exclusive
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.step, w_cmd.finish}))
        else $error("datapath commands overlap");

    // a finished block always shows up as a valid result
    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |=> m_axis_tvalid)
        else $error("finished block did not raise tvalid");
`endif

endmodule

[hdl/xtea2_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtea2_ctrl
// Sequencer: input accept, half-round stepping, output register handoff.
// ----------------------------------------------------------------------------
module xtea2_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    input  xtea2_pkg::t_dp_status   i_status,
    output xtea2_pkg::t_dp_cmd      o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_phase, n_phase;
    logic       r_out_valid, n_out_valid;
    logic       w_accept;
    logic       w_finish;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_finish    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.load   = w_accept;
        o_cmd.step   = (r_state == S_RUN);
        o_cmd.phase  = r_phase;
        o_cmd.finish = w_finish;
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                n_phase = 1'b0;
                if (w_accept) begin
                    n_state = i_status.no_rounds ? S_DONE : S_RUN;
                end
            end
            S_RUN: begin
                n_phase = !r_phase;
                if (r_phase && i_status.last_round) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_finish) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[hdl/xtea2_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtea2_dp
// Datapath: config registers, block words, sum, round counter, one shared
// Feistel unit and the output register.
// ----------------------------------------------------------------------------
module xtea2_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [xtea2_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [xtea2_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                                i_in_dir,
    input  logic [127:0]                        i_in_block,
    output logic [127:0]                        o_out_block,
    input  xtea2_pkg::t_dp_cmd                  i_cmd,
    output xtea2_pkg::t_dp_status               o_status
);

    logic [xtea2_pkg::ROUND_W-1:0] r_round_count;
    logic [31:0]                   r_key [4];
    logic [31:0]                   r_a, r_b, r_c, r_d;
    logic [31:0]                   n_a, n_b, n_c, n_d;
    logic [31:0]                   r_sum;
    logic                          r_dir;
    logic [xtea2_pkg::ROUND_W-1:0] r_cnt;
    logic [127:0]                  r_out;

    logic [31:0] w_in0, w_in1, w_in2, w_in3;
    logic [31:0] w_dec_sum;
    logic [31:0] w_p, w_q, w_x, w_f, w_k;
    logic [1:0]  w_kidx;
    logic        w_use_c;

    assign {w_in3, w_in2, w_in1, w_in0} = i_in_block;
    assign w_dec_sum = xtea2_pkg::XT_DELTA * {24'd0, r_round_count};

    assign o_status.last_round = (r_cnt == 8'd1);
    assign o_status.no_rounds  = (r_round_count == 8'd0);
    assign o_out_block         = r_out;

    // enc first half and dec second half update a from b, d;
    // the other two halves update c (enc) or b-before-rotation (dec)
    assign w_use_c = i_cmd.phase ^ r_dir;

    always_comb begin
        w_kidx = w_use_c ? r_sum[12:11] : r_sum[1:0];
        w_k    = r_key[w_kidx];
        if (!w_use_c) begin
            w_p = r_b;
            w_q = r_d;
            w_x = r_a;
        end else if (r_dir == xtea2_pkg::CMD_ENCIPHER) begin
            w_p = r_d;
            w_q = r_b;
            w_x = r_c;
        end else begin
            w_p = r_c;
            w_q = r_a;
            w_x = r_b;
        end
        w_f = xtea2_pkg::feistel(w_p, w_q, r_sum, w_k);
    end

    always_comb begin
        n_a = r_a;
        n_b = r_b;
        n_c = r_c;
        n_d = r_d;
        case ({r_dir, i_cmd.phase})
            {xtea2_pkg::CMD_ENCIPHER, 1'b0}: begin
                n_a = w_x + w_f;
            end
            {xtea2_pkg::CMD_ENCIPHER, 1'b1}: begin
                n_a = r_b;
                n_b = w_x + w_f;
                n_c = r_d;
                n_d = r_a;
            end
            {xtea2_pkg::CMD_DECIPHER, 1'b0}: begin
                n_a = r_d;
                n_b = r_a;
                n_c = w_x - w_f;
                n_d = r_c;
            end
            default: begin
                n_a = w_x - w_f;
            end
        endcase
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round_count <= xtea2_pkg::ROUND_RESET;
            r_key[0]      <= '0;
            r_key[1]      <= '0;
            r_key[2]      <= '0;
            r_key[3]      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                xtea2_pkg::CFG_ROUND_COUNT: r_round_count <= i_cfg_wdata[7:0];
                xtea2_pkg::CFG_KEY_WORD0:   r_key[0] <= i_cfg_wdata;
                xtea2_pkg::CFG_KEY_WORD1:   r_key[1] <= i_cfg_wdata;
                xtea2_pkg::CFG_KEY_WORD2:   r_key[2] <= i_cfg_wdata;
                xtea2_pkg::CFG_KEY_WORD3:   r_key[3] <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // block state
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dir <= i_in_dir;
            r_cnt <= r_round_count;
            if (i_in_dir == xtea2_pkg::CMD_ENCIPHER) begin
                r_a   <= w_in0;
                r_b   <= w_in1 + r_key[0];
                r_c   <= w_in2;
                r_d   <= w_in3 + r_key[1];
                r_sum <= '0;
            end else begin
                r_a   <= w_in0 ^ r_key[2];
                r_b   <= w_in1;
                r_c   <= w_in2 ^ r_key[3];
                r_d   <= w_in3;
                r_sum <= w_dec_sum;
            end
        end else if (i_cmd.step) begin
            r_a <= n_a;
            r_b <= n_b;
            r_c <= n_c;
            r_d <= n_d;
            if (!i_cmd.phase) begin
                r_sum <= (r_dir == xtea2_pkg::CMD_ENCIPHER) ? r_sum + xtea2_pkg::XT_DELTA
                                                            : r_sum - xtea2_pkg::XT_DELTA;
            end else begin
                r_cnt <= r_cnt - 8'd1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_dir == xtea2_pkg::CMD_ENCIPHER) begin
                r_out <= {r_d, r_c ^ r_key[3], r_b, r_a ^ r_key[2]};
            end else begin
                r_out <= {r_d - r_key[1], r_c, r_b - r_key[0], r_a};
            end
        end
    end

endmodule
